>>> sv/olte_pkg.sv
// Shared types, constants and the control program of the Ogg lacing table engine.
`timescale 1ns / 1ps

package olte_pkg;

  // Lacing value that marks a full segment
  localparam logic [7:0] SEG_FULL = 8'd255;

  // Append write pointer: segment count plus up to 258 new segments
  localparam int PTR_W = 10;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOAD   = 2'd2,
    OP_NEXT   = 2'd3
  } op_e;

  // Program steps of the sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_NEW,
    S_APP_INIT,
    S_APP_LOOP,
    S_APP_COMMIT,
    S_LOAD,
    S_NXT_CHECK,
    S_NXT_LOOP,
    S_NXT_DONE,
    S_OUT
  } step_e;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_NEW,
    A_APP_INIT,
    A_APP_STEP,
    A_APP_COMMIT,
    A_LOAD,
    A_NXT_CHECK,
    A_NXT_STEP,
    A_NXT_DONE,
    A_OUT
  } act_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_APP_LAST,
    C_NXT_EMPTY,
    C_NXT_END,
    C_OUT_FREE
  } cond_e;

  // One control word of the program
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e t_true;
    step_e t_false;
  } cw_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_fire;
    op_e  op;
    logic app_last;
    logic nxt_empty;
    logic nxt_end;
    logic out_free;
  } stat_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    act_e act;
    logic idle;
  } ctrl_t;

  // Control program ROM
  function automatic cw_t rom_word(step_e s);
    cw_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, t_true: S_IDLE, t_false: S_IDLE};
    unique case (s)
      S_IDLE:       w = '{act: A_NONE,       cond: C_ACCEPT,    t_true: S_IDLE,
                          t_false: S_IDLE};
      S_NEW:        w = '{act: A_NEW,        cond: C_ALWAYS,    t_true: S_OUT,
                          t_false: S_OUT};
      S_APP_INIT:   w = '{act: A_APP_INIT,   cond: C_ALWAYS,    t_true: S_APP_LOOP,
                          t_false: S_APP_LOOP};
      S_APP_LOOP:   w = '{act: A_APP_STEP,   cond: C_APP_LAST,  t_true: S_APP_COMMIT,
                          t_false: S_APP_LOOP};
      S_APP_COMMIT: w = '{act: A_APP_COMMIT, cond: C_ALWAYS,    t_true: S_OUT,
                          t_false: S_OUT};
      S_LOAD:       w = '{act: A_LOAD,       cond: C_ALWAYS,    t_true: S_OUT,
                          t_false: S_OUT};
      S_NXT_CHECK:  w = '{act: A_NXT_CHECK,  cond: C_NXT_EMPTY, t_true: S_OUT,
                          t_false: S_NXT_LOOP};
      S_NXT_LOOP:   w = '{act: A_NXT_STEP,   cond: C_NXT_END,   t_true: S_NXT_DONE,
                          t_false: S_NXT_LOOP};
      S_NXT_DONE:   w = '{act: A_NXT_DONE,   cond: C_ALWAYS,    t_true: S_OUT,
                          t_false: S_OUT};
      S_OUT:        w = '{act: A_OUT,        cond: C_OUT_FREE,  t_true: S_IDLE,
                          t_false: S_OUT};
      default:      w = '{act: A_NONE,       cond: C_ALWAYS,    t_true: S_IDLE,
                          t_false: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/ogg_lacing_table_engine.sv
// Top level: lacing table memory, page state datapath and output register.
// One item at a time; the next item can be taken in the cycle after the result is
// loaded, while that result may still wait. The append and walk loops handle one
// lacing entry per cycle through the table memory.
// Reset clears the step counter, segment count, read index, offset, granule and
// output valid; the lacing table is not cleared.
`timescale 1ns / 1ps

module ogg_lacing_table_engine #(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] packet_size_i,
  input  logic [31:0] sample_count_i,
  input  logic [63:0] start_granule_i,
  input  logic [7:0]  lacing_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [15:0] packet_length_o,
  output logic [15:0] byte_offset_o,
  output logic        continues_o,
  output logic [7:0]  segments_used_o,
  output logic [63:0] granule_out_o
);
  import olte_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  ctrl_t ctrl;
  stat_t stat;

  // Page state
  logic [7:0]       seg_q, seg_d;
  logic [7:0]       ri_q, ri_d;
  logic [15:0]      off_q, off_d;
  logic [63:0]      gran_q, gran_d;

  // Latched item fields
  logic [15:0]      psize_q;
  logic [31:0]      samples_q;
  logic [63:0]      start_q;
  logic [7:0]       lval_q;

  // Working registers
  logic [15:0]      left_q, left_d;
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [15:0]      plen_q, plen_d;
  logic             ok_q, ok_d;
  logic             cont_q, cont_d;
  logic [15:0]      offs_q, offs_d;

  // Lacing table memory
  logic [7:0]       mem [MAX_SEGMENTS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [7:0]       mem_wd;
  logic [7:0]       rd_q;

  logic [7:0]       app_v;
  logic             out_load;
  logic             out_valid_q, out_valid_d;

  olte_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_ready_o = ctrl.idle;
  assign out_load   = (ctrl.act == A_OUT) && stat.out_free;

  // Gather status for the sequencer
  always_comb begin
    stat.in_fire   = in_valid_i && in_ready_o;
    stat.op        = op_e'(op_i);
    stat.app_last  = (left_q < {8'd0, SEG_FULL});
    stat.nxt_empty = (ri_q >= seg_q);
    stat.nxt_end   = (rd_q != SEG_FULL) || (({1'b0, ri_q} + 9'd1) == {1'b0, seg_q});
    stat.out_free  = !out_valid_q || out_ready_i;
  end

  assign app_v = (left_q >= {8'd0, SEG_FULL}) ? SEG_FULL : left_q[7:0];

  // Execute the current action
  always_comb begin
    seg_d  = seg_q;
    ri_d   = ri_q;
    off_d  = off_q;
    gran_d = gran_q;
    left_d = left_q;
    wptr_d = wptr_q;
    plen_d = plen_q;
    ok_d   = ok_q;
    cont_d = cont_q;
    offs_d = offs_q;
    mem_we = 1'b0;
    mem_wa = seg_q[IDX_W-1:0];
    mem_wd = lval_q;

    unique case (ctrl.act)
      A_NONE, A_OUT: begin
      end
      A_NEW: begin
        seg_d  = '0;
        ri_d   = '0;
        off_d  = '0;
        gran_d = start_q;
        ok_d   = 1'b1;
        plen_d = '0;
        cont_d = 1'b0;
        offs_d = '0;
      end
      A_APP_INIT: begin
        left_d = psize_q;
        wptr_d = {{(PTR_W-8){1'b0}}, seg_q};
        plen_d = '0;
        cont_d = 1'b0;
        offs_d = off_q;
      end
      A_APP_STEP: begin
        // Write ahead of the committed count; drop writes past the table end
        mem_we = (wptr_q < PTR_W'(MAX_SEGMENTS));
        mem_wa = wptr_q[IDX_W-1:0];
        mem_wd = app_v;
        wptr_d = wptr_q + PTR_W'(1);
        left_d = left_q - {8'd0, app_v};
      end
      A_APP_COMMIT: begin
        if (wptr_q <= PTR_W'(MAX_SEGMENTS)) begin
          seg_d  = wptr_q[7:0];
          off_d  = off_q + psize_q;
          gran_d = gran_q + {32'd0, samples_q};
          ok_d   = 1'b1;
        end else begin
          ok_d   = 1'b0;
        end
      end
      A_LOAD: begin
        plen_d = '0;
        cont_d = 1'b0;
        offs_d = off_q;
        if (seg_q < 8'(MAX_SEGMENTS)) begin
          mem_we = 1'b1;
          seg_d  = seg_q + 8'd1;
          ok_d   = 1'b1;
        end else begin
          ok_d   = 1'b0;
        end
      end
      A_NXT_CHECK: begin
        plen_d = '0;
        cont_d = 1'b0;
        offs_d = off_q;
        ok_d   = 1'b0;
      end
      A_NXT_STEP: begin
        plen_d = plen_q + {8'd0, rd_q};
        ri_d   = ri_q + 8'd1;
        cont_d = (rd_q == SEG_FULL);
      end
      A_NXT_DONE: begin
        off_d = off_q + plen_q;
        ok_d  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= '0;
      ri_q        <= '0;
      off_q       <= '0;
      gran_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      ri_q        <= ri_d;
      off_q       <= off_d;
      gran_q      <= gran_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working and latched payload registers
  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    wptr_q <= wptr_d;
    plen_q <= plen_d;
    ok_q   <= ok_d;
    cont_q <= cont_d;
    offs_q <= offs_d;
    if (stat.in_fire) begin
      psize_q   <= packet_size_i;
      samples_q <= sample_count_i;
      start_q   <= start_granule_i;
      lval_q    <= lacing_value_i;
    end
  end

  // Table memory: one write port, registered read at the next read index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[ri_d[IDX_W-1:0]];
  end

  // Output register: load when free, drop when taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ok_o            <= ok_q;
      packet_length_o <= plen_q;
      byte_offset_o   <= offs_q;
      continues_o     <= cont_q;
      segments_used_o <= seg_q;
      granule_out_o   <= gran_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Segment count never passes the table size
  a_seg_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= 8'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  // Read index never passes the segment count
  a_ri_le_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ri_q <= seg_q)
    else $error("read index beyond segment count");

  // Walk only reads written entries
  a_walk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.act == A_NXT_STEP) |-> (ri_q < seg_q))
    else $error("lacing walk past the last entry");

endmodule

>>> sv/olte_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
`timescale 1ns / 1ps

module olte_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  olte_pkg::stat_t stat_i,
  output olte_pkg::ctrl_t ctrl_o
);
  import olte_pkg::*;

  step_e step_q, step_d;
  cw_t   cw;
  logic  cond_true;

  // Hold the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Fetch the control word, test its condition, pick the next step
  always_comb begin
    cw = rom_word(step_q);
    unique case (cw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_ACCEPT:    cond_true = stat_i.in_fire;
      C_APP_LAST:  cond_true = stat_i.app_last;
      C_NXT_EMPTY: cond_true = stat_i.nxt_empty;
      C_NXT_END:   cond_true = stat_i.nxt_end;
      C_OUT_FREE:  cond_true = stat_i.out_free;
      default:     cond_true = 1'b1;
    endcase

    if (!cond_true) begin
      step_d = cw.t_false;
    end else if (cw.cond == C_ACCEPT) begin
      // Dispatch on the opcode of the accepted item
      unique case (stat_i.op)
        OP_NEW:    step_d = S_NEW;
        OP_APPEND: step_d = S_APP_INIT;
        OP_LOAD:   step_d = S_LOAD;
        OP_NEXT:   step_d = S_NXT_CHECK;
        default:   step_d = S_IDLE;
      endcase
    end else begin
      step_d = cw.t_true;
    end

    ctrl_o.act  = cw.act;
    ctrl_o.idle = (step_q == S_IDLE);
  end

  // Idle holds until an item arrives
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_IDLE && !stat_i.in_fire) |=> (step_q == S_IDLE))
    else $error("sequencer left idle without an item");

  // Result step holds while the output slot is busy
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_OUT && !stat_i.out_free) |=> (step_q == S_OUT))
    else $error("result step left with output slot busy");

  // Lacing walk only loops or finishes
  a_nxt_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_NXT_LOOP) |=> (step_q == S_NXT_LOOP || step_q == S_NXT_DONE))
    else $error("lacing walk jumped to a wrong step");

endmodule
